// ----- rtl/core/lldp_pkg.sv -----
// ----------------------------------------------------------------------------
// lldp_pkg
// shared types and constants of the lldp tlv stream parser
// ----------------------------------------------------------------------------
`default_nettype none
package lldp_pkg;

  localparam int unsigned IdMaxBytes     = 255;
  localparam int unsigned MgmtMaxBytes   = 31;
  localparam int unsigned TextStoreBytes = 256;

  typedef enum logic [1:0] {
    PH_HIGH  = 2'd0,
    PH_LOW   = 2'd1,
    PH_VALUE = 2'd2
  } phase_e;

  typedef enum logic [6:0] {
    T_END     = 7'd0,
    T_CHASSIS = 7'd1,
    T_PORT    = 7'd2,
    T_TTL     = 7'd3,
    T_PDESC   = 7'd4,
    T_SNAME   = 7'd5,
    T_SDESC   = 7'd6,
    T_CAPS    = 7'd7,
    T_MGMT    = 7'd8
  } tlv_type_e;

  typedef enum logic [3:0] {
    K_CH_SUB   = 4'd0,
    K_CH_BYTE  = 4'd1,
    K_PT_SUB   = 4'd2,
    K_PT_BYTE  = 4'd3,
    K_TTL      = 4'd4,
    K_CAPS_SUP = 4'd8,
    K_CAPS_EN  = 4'd9,
    K_ADDR_SUB = 4'd10,
    K_ADDR     = 4'd11,
    K_IF_SUB   = 4'd12,
    K_IF_NUM   = 4'd13,
    K_OID      = 4'd14
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        field_valid;
    logic [3:0]  field_kind;
    logic [8:0]  field_index;
    logic [31:0] field_value;
    logic        frame_done;
    logic        frame_ok;
  } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/core/lldp_stream_if.sv -----
// ----------------------------------------------------------------------------
// lldp_stream_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
`default_nettype none
interface lldp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/lldp_tlv_stream_parser_core.sv -----
// ----------------------------------------------------------------------------
// lldp_tlv_stream_parser_core
// byte-serial lldp tlv parser producing field events and a frame status
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one lldp payload byte per transfer, last_byte marks frame end.
//   out_if : zero or one result per input byte: a field event, a done
//            status, or both in one transfer.
//   Output: each result is registered and presented in the cycle after its byte is taken.
//   Throughput: one byte per cycle while the result register is empty or drains;
//   each taken byte updates the parse state registers through combinational logic.
//   Reset: all parse state clears and the parser waits for a tlv header.
//   Stall: the result register holds while out_if.ready is low; input is
//   still taken when the result register is empty or drains this cycle.
//   After a done result, bytes are dropped until the frame's last byte.
// ----------------------------------------------------------------------------
`default_nettype none
module lldp_tlv_stream_parser_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lldp_stream_if.sink   in_if,
  lldp_stream_if.source out_if
);
  import lldp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  hdr_q, hdr_d;
  logic [6:0]  type_q, type_d;
  logic [8:0]  len_q, len_d;
  logic [8:0]  off_q, off_d;
  logic [2:0]  seen_q, seen_d;
  logic [31:0] asm_q, asm_d;
  logic [7:0]  alen_q, alen_d;
  logic [7:0]  olen_q, olen_d;
  logic        fin_q, fin_d;
  logic        ovalid_q;
  out_item_t   out_q, res;
  logic        emit_res;

  logic        take;
  logic [7:0]  b;
  logic        last;
  logic [8:0]  nlen;
  logic [6:0]  ntype;
  logic [9:0]  asl1, asl5, asl6, asl7, oend;
  logic [9:0]  offw;
  logic [31:0] shifted;
  logic [8:0]  off_inc;

  assign in_if.ready    = !ovalid_q || out_if.ready;
  assign take           = in_if.valid && in_if.ready;
  assign b              = in_if.payload.data_byte;
  assign last           = in_if.payload.last_byte;
  assign out_if.valid   = ovalid_q;
  assign out_if.payload = out_q;

  assign nlen    = {hdr_q[0], b};
  assign ntype   = hdr_q[7:1];
  assign offw    = {1'b0, off_q};
  assign asl1    = {2'b0, alen_q} + 10'd1;
  assign asl5    = {2'b0, alen_q} + 10'd5;
  assign asl6    = {2'b0, alen_q} + 10'd6;
  assign asl7    = {2'b0, alen_q} + 10'd7;
  assign oend    = asl7 + {2'b0, olen_q};
  assign shifted = {asm_q[23:0], b};
  assign off_inc = off_q + 9'd1;

  task automatic ev(inout out_item_t r, input kind_e k, input logic [8:0] i,
                    input logic [31:0] v);
    r.field_valid = 1'b1;
    r.field_kind  = k;
    r.field_index = i;
    r.field_value = v;
  endtask

  always_comb begin
    phase_d = phase_q; hdr_d = hdr_q; type_d = type_q; len_d = len_q;
    off_d = off_q; seen_d = seen_q; asm_d = asm_q; alen_d = alen_q;
    olen_d = olen_q; fin_d = fin_q;
    res = '0;
    if (fin_q) begin
      // dropping the rest of the frame
    end else begin
      case (phase_q)
        PH_HIGH: begin
          hdr_d   = b;
          phase_d = PH_LOW;
        end
        PH_LOW: begin
          type_d  = ntype;
          len_d   = nlen;
          off_d   = '0;
          asm_d   = '0;
          phase_d = (nlen == 9'd0) ? PH_HIGH : PH_VALUE;
          case (ntype)
            T_END: begin
              res.frame_done = 1'b1;
              res.frame_ok   = (nlen == 9'd0) && (seen_q == 3'b111);
              phase_d        = PH_LOW;
            end
            T_CHASSIS, T_PORT: begin
              if (nlen < 9'd2 || {1'b0, nlen} - 10'd1 > 10'(IdMaxBytes)) begin
                res.frame_done = 1'b1; phase_d = PH_LOW;
              end else begin
                seen_d = seen_q | ((ntype == T_CHASSIS) ? 3'b001 : 3'b010);
              end
            end
            T_TTL: begin
              if (nlen != 9'd2) begin
                res.frame_done = 1'b1; phase_d = PH_LOW;
              end else begin
                seen_d = seen_q | 3'b100;
              end
            end
            T_CAPS: begin
              if (nlen != 9'd4) begin res.frame_done = 1'b1; phase_d = PH_LOW; end
            end
            T_MGMT: begin
              if (nlen < 9'd8) begin res.frame_done = 1'b1; phase_d = PH_LOW; end
            end
            default: ;
          endcase
        end
        default: begin
          case (type_q)
            T_CHASSIS, T_PORT: begin
              if (off_q == 9'd0)
                ev(res, (type_q == T_CHASSIS) ? K_CH_SUB : K_PT_SUB, 9'd0, {24'd0, b});
              else
                ev(res, (type_q == T_CHASSIS) ? K_CH_BYTE : K_PT_BYTE, off_q - 9'd1,
                   {24'd0, b});
            end
            T_TTL: begin
              asm_d = shifted;
              if (off_q == 9'd1) ev(res, K_TTL, 9'd0, {16'd0, shifted[15:0]});
            end
            T_PDESC, T_SNAME, T_SDESC: begin
              if ({1'b0, off_q} < 10'(TextStoreBytes - 1))
                ev(res, kind_e'(type_q[3:0] + 4'd1), off_q, {24'd0, b});
            end
            T_CAPS: begin
              asm_d = shifted;
              if (off_q == 9'd1) ev(res, K_CAPS_SUP, 9'd0, {16'd0, shifted[15:0]});
              else if (off_q == 9'd3) ev(res, K_CAPS_EN, 9'd0, {16'd0, shifted[15:0]});
            end
            T_MGMT: begin
              if (off_q == 9'd0) begin
                alen_d = b;
                if (b < 8'd2 || {2'b0, b} - 10'd1 > 10'(MgmtMaxBytes)
                    || {2'b0, b} + 10'd7 > {1'b0, len_q})
                  res.frame_done = 1'b1;
              end else if (off_q == 9'd1) begin
                ev(res, K_ADDR_SUB, 9'd0, {24'd0, b});
              end else if (offw < asl1) begin
                ev(res, K_ADDR, off_q - 9'd2, {24'd0, b});
              end else if (offw == asl1) begin
                ev(res, K_IF_SUB, 9'd0, {24'd0, b});
              end else if (offw < asl6) begin
                asm_d = shifted;
                if (offw == asl5) ev(res, K_IF_NUM, 9'd0, shifted);
              end else if (offw == asl6) begin
                olen_d = b;
                if ({2'b0, b} > 10'(MgmtMaxBytes) || asl7 + {2'b0, b} > {1'b0, len_q})
                  res.frame_done = 1'b1;
              end else if (offw < oend) begin
                ev(res, K_OID, 9'(offw - asl7), {24'd0, b});
              end
            end
            default: ;
          endcase
          off_d = off_inc;
          if (off_inc >= len_q) phase_d = PH_HIGH;
        end
      endcase
      if (last) res.frame_done = 1'b1;
      if (res.frame_done) fin_d = 1'b1;
    end
    if (last) begin
      phase_d = PH_HIGH; hdr_d = '0; type_d = '0; len_d = '0; off_d = '0;
      seen_d = '0; asm_d = '0; alen_d = '0; olen_d = '0; fin_d = 1'b0;
    end
  end

  assign emit_res = res.field_valid || res.frame_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HIGH; hdr_q <= '0; type_q <= '0; len_q <= '0; off_q <= '0;
      seen_q <= '0; asm_q <= '0; alen_q <= '0; olen_q <= '0; fin_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q <= phase_d; hdr_q <= hdr_d; type_q <= type_d; len_q <= len_d;
        off_q <= off_d; seen_q <= seen_d; asm_q <= asm_d; alen_q <= alen_d;
        olen_q <= olen_d; fin_q <= fin_d;
      end
      if (take) ovalid_q <= emit_res;
      else if (out_if.ready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit_res) out_q <= res;
  end

`ifndef SYNTHESIS
  a_ok_has_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.payload.frame_ok |-> out_if.payload.frame_done)
    else $error("ok without done");
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && last |=> !fin_q && phase_q == PH_HIGH)
    else $error("frame state not cleared at last byte");
  a_fin_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && fin_q |=> !ovalid_q)
    else $error("result while dropping");
  a_ok_needs_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && res.frame_ok |-> seen_q == 3'b111)
    else $error("ok without mandatory tlvs");
`endif

endmodule
`default_nettype wire
